>>> rtl/ecs_pkg.sv
package ecs_pkg;

  typedef struct packed {
    logic mul;
    logic rem;
  } div_en_t;

  localparam int PADDR_W = 3;
  localparam logic [0:0] CFG_ZONE_OFFSET = 1'b0;
  localparam logic [16:0] ZONE_RESET = 17'd32400;

  localparam int SOD_LOW_W = 7;
  localparam int DAY_HI_W = 17;
  localparam int Q_HI_W = 8;
  localparam int DIV_SOD_HI = 675;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN = 60;
  localparam int DAYS_PER_WEEK = 7;
  localparam int WEEKDAY_SHIFT = 3;
  localparam int DAYS_TO_EPOCH = 719468;
  localparam int EPOCH_DAYS_W = 20;
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y = 1461;
  localparam int DAYS_1Y = 365;
  localparam int LEAP_N = 4;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [4:0] DAY_LEAP = 5'd29;
  localparam logic [3:0] MONTH_JAN_IDX = 4'd10;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

endpackage

>>> rtl/ecs_cdiv.sv
module ecs_cdiv #(
  parameter int W  = 17,
  parameter int D  = 675,
  parameter int QW = 8
) (
  input  logic                  clk,
  input  ecs_pkg::div_en_t      en,
  input  logic [W-1:0]          x,
  output logic [QW-1:0]         q,
  output logic [$clog2(D)-1:0]  r
);

  localparam int L  = $clog2(D);
  localparam int K  = W + L;
  localparam int MW = W + 1;
  localparam int PW = W + MW;
  localparam int QF = PW - K;
  localparam logic [63:0] M = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);

  logic [L-1:0]    x_lo;
  logic [PW-1:0]   prod;
  logic [QF-1:0]   q_full;
  logic [QF+L-1:0] qd;

  assign q_full = prod[PW-1:K];
  assign qd     = (QF+L)'(q_full) * (QF+L)'(D);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      x_lo <= x[L-1:0];
      prod <= PW'(x) * PW'(M[MW-1:0]);
    end
    if (en.rem) begin
      q <= q_full[QW-1:0];
      r <= x_lo - qd[L-1:0];
    end
  end

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
// Converts a Unix time in seconds to the local Gregorian date and time of day. The signed
// zone offset (APB register 0, reset +9 hours) is added first; when the adjusted time is
// negative, out_of_range is set and all other fields read zero. Weekday counts 0 for
// Monday. The block takes one beat per cycle while epoch_stall is low; the depth is set by
// the chain of constant-reciprocal multiply and remainder stages that split seconds into
// days and days into 400-, 100- and 4-year cycles, with compares for the single years.
// Stages refill as they drain, so input beats keep flowing while a result waits until
// every stage holds a beat; then epoch_stall follows result_stall in the same cycle.
module epoch_seconds_to_calendar #(
  parameter int TIME_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          epoch_valid,
  output logic                          epoch_stall,
  input  logic [TIME_BITS-1:0]          epoch_seconds,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [15:0]                   year,
  output logic [3:0]                    month,
  output logic [4:0]                    day_of_month,
  output logic [4:0]                    hour,
  output logic [5:0]                    minute,
  output logic [5:0]                    second,
  output logic [2:0]                    weekday,
  output logic                          out_of_range
);

  localparam int NS    = 14;
  localparam int AW    = TIME_BITS + 2;
  localparam int T1    = TIME_BITS + 1;
  localparam int SPLIT = T1 - ecs_pkg::SOD_LOW_W - ecs_pkg::DAY_HI_W;
  localparam int VW    = SPLIT + $clog2(ecs_pkg::DIV_SOD_HI);
  localparam int DW    = SPLIT + ecs_pkg::Q_HI_W;
  localparam int DDW   = ((DW > ecs_pkg::EPOCH_DAYS_W) ? DW : ecs_pkg::EPOCH_DAYS_W) + 1;
  localparam int Q400F = DDW + 1 - $clog2(ecs_pkg::DAYS_400Y);
  localparam int Q400W = (Q400F < 8) ? Q400F : 8;

  logic [16:0] zone_offset_seconds;

  logic [NS:1]   vld;
  logic [NS+1:1] en;
  logic [NS-1:1] neg;

  logic [AW-1:0] adj;
  logic [T1-1:0] t_s1;
  logic [SPLIT-1:0] ul_s2, ul_s3;
  logic [ecs_pkg::SOD_LOW_W-1:0] low_s2, low_s3, low_s4, low_s5;
  logic [7:0] q1a, q1_s4, q1_s5;
  logic [9:0] r1a, r2b;
  logic [SPLIT-1:0] q2b;
  logic [DW-1:0] days_s6;
  logic [DDW-1:0] dd_s6;
  logic [16:0] sod_s6;
  logic [2:0] r7;
  logic [Q400W-1:0] q400, q400_s9, q400_s10, q400_s11, q400_s12;
  logic [17:0] r400;
  logic [4:0] q3600, hour_s9, hour_s10, hour_s11, hour_s12, hour_s13;
  logic [11:0] r3600;
  logic [3:0] wsum;
  logic [2:0] wd_s9, wd_s10, wd_s11, wd_s12, wd_s13;
  logic [5:0] q60, r60, min_s11, min_s12, min_s13, sec_s11, sec_s12, sec_s13;
  logic [2:0] q100, n100_s11, n100_s12;
  logic [15:0] r100;
  logic [4:0] q1461;
  logic [10:0] r1461;
  logic [2:0] n1;
  logic [8:0] r1_s13;
  logic leap_s13;
  logic [15:0] yrp_s13;

  logic [3:0]  mi;
  logic [3:0]  mon_next;
  logic [4:0]  dom_next;
  logic [15:0] yr_next;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ecs_pkg::CFG_ZONE_OFFSET)
                ? {{15{zone_offset_seconds[16]}}, zone_offset_seconds} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_seconds <= ecs_pkg::ZONE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ecs_pkg::CFG_ZONE_OFFSET) begin
      zone_offset_seconds <= pwdata[16:0];
    end
  end

  // handshake: a stage advances when empty or when the next one advances
  assign en[NS+1]     = !result_stall;
  assign epoch_stall  = !en[1];
  assign result_valid = vld[NS];

  for (genvar s = 1; s <= NS; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= epoch_valid;
      for (int s = 2; s <= NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 2; s < NS; s++) begin
      if (en[s]) neg[s] <= neg[s-1];
    end
    if (en[1]) neg[1] <= adj[AW-1];
  end

  assign adj = {2'b00, epoch_seconds} + {{(AW-17){zone_offset_seconds[16]}}, zone_offset_seconds};

  // seconds to days: divide by 128 and then by 675 in two chunks
  ecs_cdiv #(.W(ecs_pkg::DAY_HI_W), .D(ecs_pkg::DIV_SOD_HI), .QW(8)) u_div_a (
    .clk (clk),
    .en  ('{mul: en[2], rem: en[3]}),
    .x   (t_s1[T1-1 -: ecs_pkg::DAY_HI_W]),
    .q   (q1a),
    .r   (r1a)
  );

  ecs_cdiv #(.W(VW), .D(ecs_pkg::DIV_SOD_HI), .QW(SPLIT)) u_div_b (
    .clk (clk),
    .en  ('{mul: en[4], rem: en[5]}),
    .x   ({r1a, ul_s3}),
    .q   (q2b),
    .r   (r2b)
  );

  ecs_cdiv #(.W(DW), .D(ecs_pkg::DAYS_PER_WEEK), .QW(1)) u_div_wk (
    .clk (clk),
    .en  ('{mul: en[7], rem: en[8]}),
    .x   (days_s6),
    .q   (),
    .r   (r7)
  );

  ecs_cdiv #(.W(DDW), .D(ecs_pkg::DAYS_400Y), .QW(Q400W)) u_div_400 (
    .clk (clk),
    .en  ('{mul: en[7], rem: en[8]}),
    .x   (dd_s6),
    .q   (q400),
    .r   (r400)
  );

  ecs_cdiv #(.W(17), .D(ecs_pkg::SECS_PER_HOUR), .QW(5)) u_div_hr (
    .clk (clk),
    .en  ('{mul: en[7], rem: en[8]}),
    .x   (sod_s6),
    .q   (q3600),
    .r   (r3600)
  );

  ecs_cdiv #(.W(12), .D(ecs_pkg::SECS_PER_MIN), .QW(6)) u_div_min (
    .clk (clk),
    .en  ('{mul: en[9], rem: en[10]}),
    .x   (r3600),
    .q   (q60),
    .r   (r60)
  );

  ecs_cdiv #(.W(18), .D(ecs_pkg::DAYS_100Y), .QW(3)) u_div_100 (
    .clk (clk),
    .en  ('{mul: en[9], rem: en[10]}),
    .x   (r400),
    .q   (q100),
    .r   (r100)
  );

  ecs_cdiv #(.W(16), .D(ecs_pkg::DAYS_4Y), .QW(5)) u_div_4 (
    .clk (clk),
    .en  ('{mul: en[11], rem: en[12]}),
    .x   (r100),
    .q   (q1461),
    .r   (r1461)
  );

  assign wsum = {1'b0, r7} + 4'(ecs_pkg::WEEKDAY_SHIFT);

  always_comb begin
    if (r1461 >= 11'(4 * ecs_pkg::DAYS_1Y)) begin
      n1 = 3'd4;
    end else if (r1461 >= 11'(3 * ecs_pkg::DAYS_1Y)) begin
      n1 = 3'd3;
    end else if (r1461 >= 11'(2 * ecs_pkg::DAYS_1Y)) begin
      n1 = 3'd2;
    end else if (r1461 >= 11'(ecs_pkg::DAYS_1Y)) begin
      n1 = 3'd1;
    end else begin
      n1 = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_s1 <= adj[T1-1:0];
    end
    if (en[2]) begin
      ul_s2  <= t_s1[ecs_pkg::SOD_LOW_W +: SPLIT];
      low_s2 <= t_s1[ecs_pkg::SOD_LOW_W-1:0];
    end
    if (en[3]) begin
      ul_s3  <= ul_s2;
      low_s3 <= low_s2;
    end
    if (en[4]) begin
      q1_s4  <= q1a;
      low_s4 <= low_s3;
    end
    if (en[5]) begin
      q1_s5  <= q1_s4;
      low_s5 <= low_s4;
    end
    if (en[6]) begin
      days_s6 <= {q1_s5, q2b};
      dd_s6   <= DDW'({q1_s5, q2b}) + DDW'(ecs_pkg::DAYS_TO_EPOCH);
      sod_s6  <= {r2b, low_s5};
    end
    if (en[9]) begin
      wd_s9   <= (wsum >= 4'(ecs_pkg::DAYS_PER_WEEK))
               ? 3'(wsum - 4'(ecs_pkg::DAYS_PER_WEEK)) : wsum[2:0];
      hour_s9 <= q3600;
      q400_s9 <= q400;
    end
    if (en[10]) begin
      wd_s10   <= wd_s9;
      hour_s10 <= hour_s9;
      q400_s10 <= q400_s9;
    end
    if (en[11]) begin
      wd_s11   <= wd_s10;
      hour_s11 <= hour_s10;
      q400_s11 <= q400_s10;
      min_s11  <= q60;
      sec_s11  <= r60;
      n100_s11 <= q100;
    end
    if (en[12]) begin
      wd_s12   <= wd_s11;
      hour_s12 <= hour_s11;
      q400_s12 <= q400_s11;
      min_s12  <= min_s11;
      sec_s12  <= sec_s11;
      n100_s12 <= n100_s11;
    end
    if (en[13]) begin
      wd_s13   <= wd_s12;
      hour_s13 <= hour_s12;
      min_s13  <= min_s12;
      sec_s13  <= sec_s12;
      r1_s13   <= 9'(r1461 - 11'(n1) * 11'(ecs_pkg::DAYS_1Y));
      leap_s13 <= (n100_s12 == 3'(ecs_pkg::LEAP_N)) || (n1 == 3'(ecs_pkg::LEAP_N));
      yrp_s13  <= 16'(q400_s12) * 16'd400 + 16'(n100_s12) * 16'd100
                + 16'(q1461) * 16'd4 + 16'(n1);
    end
  end

  // month from the March-based table of month starts
  always_comb begin
    mi = 4'd0;
    for (int j = 1; j < 12; j++) begin
      if (r1_s13 >= ecs_pkg::MONTH_START[j]) mi = 4'(j);
    end
    dom_next = 5'(r1_s13 - ecs_pkg::MONTH_START[mi] + 9'd1);
    mon_next = mi + 4'd3;
    yr_next  = yrp_s13;
    if (leap_s13) begin
      mon_next = ecs_pkg::MONTH_FEB;
      dom_next = ecs_pkg::DAY_LEAP;
    end else if (mi >= ecs_pkg::MONTH_JAN_IDX) begin
      mon_next = mi - 4'd9;
      yr_next  = yrp_s13 + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      if (neg[NS-1]) begin
        year         <= '0;
        month        <= '0;
        day_of_month <= '0;
        hour         <= '0;
        minute       <= '0;
        second       <= '0;
        weekday      <= '0;
        out_of_range <= 1'b1;
      end else begin
        year         <= yr_next;
        month        <= mon_next;
        day_of_month <= dom_next;
        hour         <= hour_s13;
        minute       <= min_s13;
        second       <= sec_s13;
        weekday      <= wd_s13;
        out_of_range <= 1'b0;
      end
    end
  end

  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !epoch_stall)
    else $error("input stalled while output drains");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_of_range |->
      month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
      hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6)
    else $error("calendar field out of range");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_range |->
      year == 16'd0 && month == 4'd0 && day_of_month == 5'd0 && hour == 5'd0 &&
      minute == 6'd0 && second == 6'd0 && weekday == 3'd0)
    else $error("out-of-range beat carries nonzero fields");

endmodule
